>>> sv/rsdi_pkg.sv
package rsdi_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 28;

    // Register indexes on the configuration port.
    localparam logic [CFG_AW-1:0] CFG_BOOST_THRUST   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BOOST_TIME     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SUSTAIN_THRUST = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SUSTAIN_TIME   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_INV_MASS       = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DRAG_SCALE     = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_SOUND_SPEED    = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_INITIAL_SPEED  = 3'd7;

    // Register values after reset.
    localparam logic [19:0] RST_BOOST_THRUST   = 20'd17800;
    localparam logic [23:0] RST_BOOST_TIME     = 24'd183501;
    localparam logic [19:0] RST_SUSTAIN_THRUST = 20'd4500;
    localparam logic [23:0] RST_SUSTAIN_TIME   = 24'd734003;
    localparam logic [23:0] RST_INV_MASS       = 24'd72628;
    localparam logic [23:0] RST_DRAG_SCALE     = 24'd213900;
    localparam logic [25:0] RST_SOUND_SPEED    = 26'd21207450;
    localparam logic [27:0] RST_INITIAL_SPEED  = 28'd65536000;

    // Drag coefficients in Q0.16.
    localparam logic [15:0] COEF_FAST = 16'd13107;
    localparam logic [15:0] COEF_SLOW = 16'd32768;

    localparam logic [1:0] PH_BOOST   = 2'd0;
    localparam logic [1:0] PH_SUSTAIN = 2'd1;
    localparam logic [1:0] PH_GLIDE   = 2'd2;

    typedef struct packed {
        logic [19:0] boost_thrust;
        logic [23:0] boost_time;
        logic [19:0] sustain_thrust;
        logic [23:0] sustain_time;
        logic [23:0] inv_mass;
        logic [23:0] drag_scale;
        logic [25:0] sound_speed;
        logic [27:0] initial_speed;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] pos;
        logic [23:0]        boost_left;
        logic [23:0]        sustain_left;
    } t_state;

    typedef struct packed {
        t_state     st;
        logic [1:0] phase;
        logic       supersonic;
    } t_step_res;

endpackage

>>> sv/rsdi_mul.sv
module rsdi_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= {32'd0, i_a} * {32'd0, i_b};
    end

endmodule

>>> sv/rsdi_core.sv
module rsdi_core #(
    parameter int WORLD_SPAN = 10000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_dt,
    input  rsdi_pkg::t_cfg     i_cfg,
    input  rsdi_pkg::t_state   i_st,
    input  logic               i_out_free,
    output logic               o_idle,
    output logic               o_done,
    output rsdi_pkg::t_step_res o_res
);

    localparam logic signed [33:0] SPAN_Q = 34'(WORLD_SPAN * 65536);
    localparam logic signed [49:0] V_MAX  = 50'sd2147483647;
    localparam logic signed [49:0] V_MIN  = -50'sd2147483648;
    localparam logic signed [33:0] P_MAX  = 34'sd2147483647;
    localparam logic signed [33:0] P_MIN  = -34'sd2147483648;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_D1, S_D2, S_D3, S_C1, S_C2, S_C3, S_F,
        S_A1, S_A2, S_A3, S_V1, S_V2, S_V3, S_N, S_P1, S_P2, S_FIN
    } t_seq;

    t_seq               r_state;
    logic [15:0]        r_dt;
    logic [31:0]        r_vm;
    logic               r_fast;
    logic [47:0]        r_w;
    logic [23:0]        r_t;
    logic               r_neg;
    logic signed [31:0] r_nv;
    logic signed [33:0] r_np;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [15:0]        coef;
    logic [47:0]        thrust_q;
    logic               n_neg;
    logic signed [49:0] n_vsum;
    logic signed [33:0] n_psum;
    logic signed [33:0] wrap_p;
    logic signed [31:0] fin_pos;
    logic [23:0]        fin_bl;
    logic [23:0]        fin_sl;

    rsdi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign coef = r_fast ? rsdi_pkg::COEF_FAST : rsdi_pkg::COEF_SLOW;

    // Operand selection for the shared multiplier; wide values go in as 24-bit halves.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ: begin
                mul_a = r_vm;
                mul_b = r_vm;
            end
            S_D1: begin
                mul_a = {8'd0, mul_p[39:16]};
                mul_b = {8'd0, i_cfg.drag_scale};
            end
            S_D2: begin
                mul_a = {8'd0, r_w[47:24]};
                mul_b = {8'd0, i_cfg.drag_scale};
            end
            S_C1: begin
                mul_a = {8'd0, r_w[23:0]};
                mul_b = {16'd0, coef};
            end
            S_C2: begin
                mul_a = {8'd0, r_w[47:24]};
                mul_b = {16'd0, coef};
            end
            S_A1: begin
                mul_a = {8'd0, r_w[23:0]};
                mul_b = {8'd0, i_cfg.inv_mass};
            end
            S_A2: begin
                mul_a = {8'd0, r_w[47:24]};
                mul_b = {8'd0, i_cfg.inv_mass};
            end
            S_V1: begin
                mul_a = {8'd0, r_w[23:0]};
                mul_b = {16'd0, r_dt};
            end
            S_V2: begin
                mul_a = {8'd0, r_w[47:24]};
                mul_b = {16'd0, r_dt};
            end
            S_P1: begin
                mul_a = r_nv[31] ? 32'(-r_nv) : 32'(r_nv);
                mul_b = {16'd0, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (i_st.boost_left != '0) begin
            thrust_q = {12'd0, i_cfg.boost_thrust, 16'd0};
        end else if (i_st.sustain_left != '0) begin
            thrust_q = {12'd0, i_cfg.sustain_thrust, 16'd0};
        end else begin
            thrust_q = '0;
        end
    end

    assign n_neg  = r_w > thrust_q;
    assign n_vsum = r_neg ? ({{18{i_st.vel[31]}}, i_st.vel} - {2'b00, r_w})
                          : ({{18{i_st.vel[31]}}, i_st.vel} + {2'b00, r_w});
    assign n_psum = r_nv[31] ? ({{2{i_st.pos[31]}}, i_st.pos} - {2'b00, mul_p[47:16]})
                             : ({{2{i_st.pos[31]}}, i_st.pos} + {2'b00, mul_p[47:16]});

    // Final step: single wrap past the world edge, saturate, count down the active timer.
    always_comb begin
        wrap_p = (r_np > SPAN_Q) ? (r_np - SPAN_Q) : r_np;
        if (wrap_p > P_MAX) begin
            fin_pos = 32'sh7FFFFFFF;
        end else if (wrap_p < P_MIN) begin
            fin_pos = 32'sh80000000;
        end else begin
            fin_pos = wrap_p[31:0];
        end
        fin_bl = i_st.boost_left;
        fin_sl = i_st.sustain_left;
        if (i_st.boost_left != '0) begin
            fin_bl = (i_st.boost_left > {8'd0, r_dt}) ? (i_st.boost_left - {8'd0, r_dt}) : '0;
        end else if (i_st.sustain_left != '0) begin
            fin_sl = (i_st.sustain_left > {8'd0, r_dt}) ?
                     (i_st.sustain_left - {8'd0, r_dt}) : '0;
        end
    end

    always_comb begin
        o_res.st.vel          = r_nv;
        o_res.st.pos          = fin_pos;
        o_res.st.boost_left   = fin_bl;
        o_res.st.sustain_left = fin_sl;
        if (fin_bl != '0) begin
            o_res.phase = rsdi_pkg::PH_BOOST;
        end else if (fin_sl != '0) begin
            o_res.phase = rsdi_pkg::PH_SUSTAIN;
        end else begin
            o_res.phase = rsdi_pkg::PH_GLIDE;
        end
        o_res.supersonic = $signed({r_nv[31], r_nv}) >= $signed({7'd0, i_cfg.sound_speed});
    end

    assign o_idle = r_state == S_IDLE;
    assign o_done = (r_state == S_FIN) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dt    <= i_dt;
                        r_vm    <= i_st.vel[31] ? 32'(-i_st.vel) : 32'(i_st.vel);
                        r_fast  <= $signed({i_st.vel[31], i_st.vel}) >=
                                   $signed({7'd0, i_cfg.sound_speed});
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_D1;
                S_D1: begin
                    r_w     <= {1'b0, mul_p[62:16]};
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_t     <= mul_p[47:24];
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_w     <= mul_p[47:0] + {24'd0, r_t};
                    r_state <= S_C1;
                end
                S_C1: r_state <= S_C2;
                S_C2: begin
                    r_t     <= mul_p[39:16];
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_w     <= {mul_p[39:0], 8'd0} + {24'd0, r_t};
                    r_state <= S_F;
                end
                S_F: begin
                    r_neg   <= n_neg;
                    r_w     <= n_neg ? (r_w - thrust_q) : (thrust_q - r_w);
                    r_state <= S_A1;
                end
                S_A1: r_state <= S_A2;
                S_A2: begin
                    r_t     <= mul_p[47:24];
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_w     <= mul_p[47:0] + {24'd0, r_t};
                    r_state <= S_V1;
                end
                S_V1: r_state <= S_V2;
                S_V2: begin
                    r_t     <= mul_p[39:16];
                    r_state <= S_V3;
                end
                S_V3: begin
                    r_w     <= {mul_p[39:0], 8'd0} + {24'd0, r_t};
                    r_state <= S_N;
                end
                S_N: begin
                    if (n_vsum > V_MAX) begin
                        r_nv <= 32'sh7FFFFFFF;
                    end else if (n_vsum < V_MIN) begin
                        r_nv <= 32'sh80000000;
                    end else begin
                        r_nv <= n_vsum[31:0];
                    end
                    r_state <= S_P1;
                end
                S_P1: r_state <= S_P2;
                S_P2: begin
                    r_np    <= n_psum;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/rocket_stage_drag_integrator_top.sv
// Horizontal rocket integrator: one input transaction on s_axis carries a time
// step dt (tick_time, Q0.16). For each one the block updates speed and position
// from the active stage's thrust and quadratic drag and sends one result
// transaction on m_axis with the new speed, wrapped position, stage and a
// supersonic flag.
// Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata; the user
// must write them only while the block is idle, which the block does not enforce;
// writing boost_time, sustain_time or initial_speed also reloads the matching
// timer or the speed.
// The block takes no new item before it is through with the last one, since its
// work is ten dependent products that go one after another through the single
// 32x32 multiplier, with the adds between them.
// s_axis_tready is high only while the sequencer is idle. A finished result sits
// in the output register, so the next item can be accepted while it waits; if
// the receiver still stalls when the following result is done, the sequencer
// holds in its last step until the register frees.
// Reset (synchronous, active low) restores all registers to their defaults,
// loads speed and both timers from them, zeroes the position and empties the
// output register.
module rocket_stage_drag_integrator_top #(
    parameter int WORLD_SPAN = 10000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [15:0] tick_time
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [31:0] speed_out, [63:32] position_out, [65:64] phase, [66] supersonic
    output logic [71:0]                 m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [rsdi_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [rsdi_pkg::CFG_DW-1:0] i_cfg_wdata
);

    rsdi_pkg::t_cfg      r_cfg;
    rsdi_pkg::t_state    r_st;
    rsdi_pkg::t_step_res r_out;
    logic                r_out_valid;

    rsdi_pkg::t_step_res core_res;
    logic                core_idle;
    logic                core_done;
    logic                out_free;
    logic                start;

    assign out_free = !r_out_valid || m_axis_tready;
    assign start    = s_axis_tvalid && core_idle;

    rsdi_core #(
        .WORLD_SPAN (WORLD_SPAN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dt       (s_axis_tdata),
        .i_cfg      (r_cfg),
        .i_st       (r_st),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boost_thrust   <= rsdi_pkg::RST_BOOST_THRUST;
            r_cfg.boost_time     <= rsdi_pkg::RST_BOOST_TIME;
            r_cfg.sustain_thrust <= rsdi_pkg::RST_SUSTAIN_THRUST;
            r_cfg.sustain_time   <= rsdi_pkg::RST_SUSTAIN_TIME;
            r_cfg.inv_mass       <= rsdi_pkg::RST_INV_MASS;
            r_cfg.drag_scale     <= rsdi_pkg::RST_DRAG_SCALE;
            r_cfg.sound_speed    <= rsdi_pkg::RST_SOUND_SPEED;
            r_cfg.initial_speed  <= rsdi_pkg::RST_INITIAL_SPEED;
            r_st.vel             <= $signed({4'd0, rsdi_pkg::RST_INITIAL_SPEED});
            r_st.pos             <= '0;
            r_st.boost_left      <= rsdi_pkg::RST_BOOST_TIME;
            r_st.sustain_left    <= rsdi_pkg::RST_SUSTAIN_TIME;
        end else if (core_done) begin
            r_st <= core_res.st;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rsdi_pkg::CFG_BOOST_THRUST:   r_cfg.boost_thrust <= i_cfg_wdata[19:0];
                rsdi_pkg::CFG_BOOST_TIME: begin
                    r_cfg.boost_time <= i_cfg_wdata[23:0];
                    r_st.boost_left  <= i_cfg_wdata[23:0];
                end
                rsdi_pkg::CFG_SUSTAIN_THRUST: r_cfg.sustain_thrust <= i_cfg_wdata[19:0];
                rsdi_pkg::CFG_SUSTAIN_TIME: begin
                    r_cfg.sustain_time <= i_cfg_wdata[23:0];
                    r_st.sustain_left  <= i_cfg_wdata[23:0];
                end
                rsdi_pkg::CFG_INV_MASS:       r_cfg.inv_mass <= i_cfg_wdata[23:0];
                rsdi_pkg::CFG_DRAG_SCALE:     r_cfg.drag_scale <= i_cfg_wdata[23:0];
                rsdi_pkg::CFG_SOUND_SPEED:    r_cfg.sound_speed <= i_cfg_wdata[25:0];
                rsdi_pkg::CFG_INITIAL_SPEED: begin
                    r_cfg.initial_speed <= i_cfg_wdata[27:0];
                    r_st.vel            <= $signed({4'd0, i_cfg_wdata[27:0]});
                end
                default: ;
            endcase
        end
    end

    // Output register: loaded when the sequencer finishes, emptied by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
            r_out       <= core_res;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = core_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.supersonic, r_out.phase,
                            r_out.st.pos, r_out.st.vel};

    // Only one item is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // The boost timer only counts down unless it is reloaded.
    a_boost_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_we && i_cfg_addr == rsdi_pkg::CFG_BOOST_TIME)
        |=> r_st.boost_left <= $past(r_st.boost_left))
        else $error("boost timer increased without a reload");

    // The sustainer timer does not move while the boost stage is still burning.
    a_sustain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.boost_left != '0 && !(i_cfg_we && i_cfg_addr == rsdi_pkg::CFG_SUSTAIN_TIME))
        |=> $stable(r_st.sustain_left))
        else $error("sustainer timer changed during boost");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (!r_out_valid || m_axis_tready))
        else $error("result register overwritten");

endmodule
